// ===== rtl/core/fm_index_occurrence_query_core_macros.svh =====
// Assertion macros shared by the occurrence query RTL.
`ifndef FM_INDEX_OCCURRENCE_QUERY_CORE_MACROS_SVH
`define FM_INDEX_OCCURRENCE_QUERY_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define FMQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FMQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/fmq_pkg.sv =====
// Package with constants, codes, types and the symbol count function of the occurrence query.
package fmq_pkg;

  localparam int SYMBOLS_PER_INTERVAL = 128;
  localparam int MEMORY_WORDS         = 1048576;

  localparam int WORD_W        = 32;
  localparam int SYMS_PER_WORD = WORD_W / 2;
  localparam int CKPT_WORDS    = 8;
  localparam int WORDS_PER_INTERVAL = CKPT_WORDS + SYMBOLS_PER_INTERVAL / SYMS_PER_WORD;
  localparam int ADDR_W   = $clog2(MEMORY_WORDS);
  localparam int SPI_LOG2 = $clog2(SYMBOLS_PER_INTERVAL);
  localparam int SPW_LOG2 = $clog2(SYMS_PER_WORD);
  localparam int IDX_W    = $clog2(WORDS_PER_INTERVAL);
  localparam int COUNT_W  = 33;
  localparam int POS_W    = 34;
  localparam int CNT_W    = $clog2(SYMS_PER_WORD + 1);
  localparam int CMD_W    = 2;
  localparam int SYM_W    = 2;
  localparam int LOAD_ADDR_W = 20;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CMD_W-1:0] CMD_LOAD      = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY_ONE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY_ALL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PRIMARY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_A    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_C    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_G    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_T    = 3'd5;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PREP  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_FLUSH = 6'b001000,
    ST_POST  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  // Number of 2-bit fields in a word that equal the given symbol.
  function automatic logic [CNT_W-1:0] count_symbol(input logic [WORD_W-1:0] w,
                                                    input logic [SYM_W-1:0] sym);
    logic [SYMS_PER_WORD-1:0] hit;
    for (int i = 0; i < SYMS_PER_WORD; i++) begin
      hit[i] = (w[2*i +: 2] == sym);
    end
    return CNT_W'($countones(hit));
  endfunction

endpackage

// ===== rtl/core/fm_index_occurrence_query_core.sv =====
// Top level of the FM-index occurrence query engine with its word memory and sequencer.
//
// Usage: the input channel (in_valid / in_stall) takes one word per handshake. A load
// command writes load_word to load_address of the occurrence memory in the accepting
// cycle and gives no result. A query command (one symbol or all four) returns one
// result word on the output channel (out_valid / out_stall) with counts at position_k
// and position_l. Command code 3 is dropped without a result.
// Each position is prepared, then reads eight checkpoint words and F + 1 symbol words,
// where F = (row mod 128) / 16 is the number of whole symbol words before the addressed
// one (0 to 7), then flushes and stores its result; a position that needs no memory read
// goes from preparation straight to its result. The single memory read port, one 32-bit
// word a cycle, feeds one shared counting unit.
// The engine takes no new word while a query is in progress; it does take one while
// a finished result waits in the output register. When the receiver stalls, the
// result and out_valid hold, and a later query waits in its last step until the
// output register is free. Reset clears the sequencer, the output valid flag and all
// configuration registers; memory contents are undefined until loaded. The user must
// write configuration via cfg_write / cfg_index / cfg_data while idle (not enforced).
`include "fm_index_occurrence_query_core_macros.svh"

module fm_index_occurrence_query_core import fmq_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [COUNT_W-1:0]          cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [CMD_W-1:0]            command,
  input  logic [LOAD_ADDR_W-1:0]      load_address,
  input  logic [WORD_W-1:0]           load_word,
  input  logic signed [POS_W-1:0]     position_k,
  input  logic signed [POS_W-1:0]     position_l,
  input  logic [SYM_W-1:0]            symbol,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [COUNT_W-1:0]          occ_k_a,
  output logic [COUNT_W-1:0]          occ_k_c,
  output logic [COUNT_W-1:0]          occ_k_g,
  output logic [COUNT_W-1:0]          occ_k_t,
  output logic [COUNT_W-1:0]          occ_l_a,
  output logic [COUNT_W-1:0]          occ_l_c,
  output logic [COUNT_W-1:0]          occ_l_g,
  output logic [COUNT_W-1:0]          occ_l_t
);

  // Configuration registers.
  logic [COUNT_W-1:0] primary_position;
  logic [COUNT_W-1:0] sequence_length;
  logic [COUNT_W-1:0] total_count [4];

  // Sequencer.
  state_t state, state_next;
  logic   in_accept;
  logic   query_cmd;

  // Captured query.
  logic                 mode_one;
  logic [SYM_W-1:0]     sym_q;
  logic [POS_W-1:0]     pos_k_q;
  logic [POS_W-1:0]     pos_l_q;
  logic                 pos_sel;

  // Per-position setup worked out in the preparation step.
  logic [POS_W-1:0]     cur_pos;
  logic [COUNT_W-1:0]   cur_row;
  logic                 past_primary;
  logic [COUNT_W-1:0]   row;
  logic [COUNT_W-1:0]   interval;
  logic [SPI_LOG2-1:0]  offs;
  logic [3:0]           masked;
  logic                 prep_zero;
  logic                 prep_total;

  logic [ADDR_W-1:0]    base_addr;
  logic [IDX_W-1:0]     last_idx;
  logic [WORD_W-1:0]    keep_mask;
  logic [3:0]           masked_cnt;
  logic                 zero_q;
  logic                 total_q;

  // Memory read pipeline.
  logic [WORD_W-1:0]    mem [MEMORY_WORDS];
  logic [IDX_W-1:0]     idx;
  logic [ADDR_W-1:0]    rd_addr;
  logic                 rd_valid;
  logic [IDX_W-1:0]     rd_idx;
  logic                 rd_last;
  logic [WORD_W-1:0]    rdata;

  // Shared counting unit and accumulators.
  logic [WORD_W-1:0]    data_word;
  logic [CNT_W-1:0]     cnt [4];
  logic [COUNT_W-1:0]   acc [4];
  logic [COUNT_W-1:0]   post_val [4];

  // Result holding and output registers.
  logic [COUNT_W-1:0]   res_k [4];
  logic [COUNT_W-1:0]   res_l [4];
  logic [COUNT_W-1:0]   out_k [4];
  logic [COUNT_W-1:0]   out_l [4];
  logic                 out_load;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign query_cmd = (command inside {CMD_QUERY_ONE, CMD_QUERY_ALL});
  assign out_load  = (state == ST_DONE) && (!out_valid || !out_stall);

  // Row arithmetic: the sentinel row is skipped, so rows at or past it move down by one.
  // A position at row zero that is also at or past the sentinel has nothing before it.
  always_comb begin
    cur_pos      = pos_sel ? pos_l_q : pos_k_q;
    cur_row      = cur_pos[COUNT_W-1:0];
    past_primary = (cur_row >= primary_position);
    row          = past_primary ? (cur_row - COUNT_W'(1)) : cur_row;
    interval     = row >> SPI_LOG2;
    offs         = row[SPI_LOG2-1:0];
    masked       = 4'(SYMS_PER_WORD - 1) - offs[SPW_LOG2-1:0];
    prep_zero    = cur_pos[POS_W-1] || (past_primary && (cur_row == '0));
    prep_total   = mode_one && (cur_pos == {1'b0, sequence_length});
  end

  assign rd_addr = base_addr + ADDR_W'(idx);

  // The last symbol word keeps only the symbols up to the position; the cleared
  // fields read as symbol A and are taken back out of the A count.
  assign data_word = rd_last ? (rdata & keep_mask) : rdata;

  always_comb begin
    for (int s = 0; s < 4; s++) begin
      cnt[s] = count_symbol(data_word, SYM_W'(s));
    end
  end

  // Value of each symbol slot once a position is complete. In one-symbol mode the
  // sequence-length total takes precedence over the empty first row.
  always_comb begin
    for (int s = 0; s < 4; s++) begin
      if (mode_one && (SYM_W'(s) != sym_q)) begin
        post_val[s] = '0;
      end else if (total_q) begin
        post_val[s] = total_count[s];
      end else if (zero_q) begin
        post_val[s] = '0;
      end else begin
        post_val[s] = acc[s];
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_accept && query_cmd) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        if (prep_zero || prep_total) begin
          state_next = ST_POST;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (idx == last_idx) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_next = ST_POST;
      end
      ST_POST: begin
        if (pos_sel) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_PREP;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      rd_valid         <= 1'b0;
      primary_position <= '0;
      sequence_length  <= '0;
      for (int s = 0; s < 4; s++) begin
        total_count[s] <= '0;
      end
    end else begin
      state    <= state_next;
      rd_valid <= (state == ST_READ);
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_PRIMARY:    primary_position <= cfg_data;
          REG_SEQ_LENGTH: sequence_length  <= cfg_data;
          REG_TOTAL_A:    total_count[0]   <= cfg_data;
          REG_TOTAL_C:    total_count[1]   <= cfg_data;
          REG_TOTAL_G:    total_count[2]   <= cfg_data;
          REG_TOTAL_T:    total_count[3]   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  // Occurrence memory: one write port for loads, one registered read port for queries.
  always_ff @(posedge clk) begin
    if (in_accept && (command == CMD_LOAD)) begin
      mem[ADDR_W'(load_address)] <= load_word;
    end
    if (state == ST_READ) begin
      rdata <= mem[rd_addr];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_accept && query_cmd) begin
      mode_one <= (command == CMD_QUERY_ONE);
      sym_q    <= symbol;
      pos_k_q  <= position_k;
      pos_l_q  <= position_l;
      pos_sel  <= 1'b0;
    end

    if (state == ST_PREP) begin
      base_addr  <= ADDR_W'(ADDR_W'(interval) * ADDR_W'(WORDS_PER_INTERVAL));
      last_idx   <= IDX_W'(CKPT_WORDS) + IDX_W'(offs >> SPW_LOG2);
      keep_mask  <= ~((WORD_W'(1) << {masked, 1'b0}) - WORD_W'(1));
      masked_cnt <= masked;
      zero_q     <= prep_zero;
      total_q    <= prep_total;
      idx        <= '0;
    end

    if (state == ST_READ) begin
      idx     <= idx + IDX_W'(1);
      rd_idx  <= idx;
      rd_last <= (idx == last_idx);
    end

    // Checkpoint words load the accumulators (low word, then bit 0 of the high word
    // as the top count bit); symbol words add their per-symbol counts.
    if (rd_valid) begin
      if (rd_idx < IDX_W'(CKPT_WORDS)) begin
        if (!rd_idx[0]) begin
          acc[rd_idx[2:1]][WORD_W-1:0] <= rdata;
        end else begin
          acc[rd_idx[2:1]][COUNT_W-1] <= rdata[0];
        end
      end else begin
        for (int s = 0; s < 4; s++) begin
          if ((s == 0) && rd_last) begin
            acc[s] <= acc[s] + COUNT_W'(cnt[s]) - COUNT_W'(masked_cnt);
          end else begin
            acc[s] <= acc[s] + COUNT_W'(cnt[s]);
          end
        end
      end
    end

    if (state == ST_POST) begin
      for (int s = 0; s < 4; s++) begin
        if (pos_sel) begin
          res_l[s] <= post_val[s];
        end else begin
          res_k[s] <= post_val[s];
        end
      end
      pos_sel <= 1'b1;
    end

    if (out_load) begin
      for (int s = 0; s < 4; s++) begin
        out_k[s] <= res_k[s];
        out_l[s] <= res_l[s];
      end
    end
  end

  assign occ_k_a = out_k[0];
  assign occ_k_c = out_k[1];
  assign occ_k_g = out_k[2];
  assign occ_k_t = out_k[3];
  assign occ_l_a = out_l[0];
  assign occ_l_c = out_l[1];
  assign occ_l_g = out_l[2];
  assign occ_l_t = out_l[3];

  // The last symbol word of a position returns exactly in the flush step.
  `FMQ_ASSERT_SAME(a_flush_has_last, state == ST_FLUSH, rd_valid && rd_last, "flush without last read")
  // While addresses are still issued, no returning word is marked last.
  `FMQ_ASSERT_SAME(a_read_not_last, (state == ST_READ) && rd_valid, !rd_last, "early last read")
  // An accepted query starts the preparation of position k.
  `FMQ_ASSERT_NEXT(a_query_starts, in_accept && query_cmd, state == ST_PREP, "query not started")
  // A finished query moves into the output register and frees the input side.
  `FMQ_ASSERT_NEXT(a_done_to_out, out_load, out_valid && (state == ST_IDLE), "result not presented")

endmodule
